FILE: rtl/alsd_pkg.sv
// ----------------------------------------------------------------------------
// alsd_pkg
// shared types, codes and sizes of the led strip driver
// ----------------------------------------------------------------------------
package alsd_pkg;

    localparam int MAX_PIXELS = 64;
    // memory address width
    localparam int PIX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    // width that holds a pixel count up to MAX_PIXELS and any pixel_count value
    localparam int CNT_W = ($clog2(MAX_PIXELS + 1) > 7) ? $clog2(MAX_PIXELS + 1) : 7;
    localparam int WORD_W = 24;
    localparam int BIT_LAST = WORD_W - 1;

    localparam logic [6:0]  PIXEL_COUNT_RST = 7'd60;
    localparam logic [7:0]  PERIOD_TOP_RST  = 8'd50;
    localparam logic [7:0]  ONE_HIGH_RST    = 8'd40;
    localparam logic [7:0]  ZERO_HIGH_RST   = 8'd10;
    localparam logic [16:0] LATCH_TICKS_RST = 17'd74880;

    typedef enum logic [2:0] {
        MODE_WRITE  = 3'd0,
        MODE_READ   = 3'd1,
        MODE_COMMIT = 3'd2,
        MODE_DRAW   = 3'd3,
        MODE_TICK   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_COMMIT = 2'd1,
        PH_SEND   = 2'd2,
        PH_LATCH  = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        REG_PIXEL_COUNT = 3'd0,
        REG_PERIOD_TOP  = 3'd1,
        REG_ONE_HIGH    = 3'd2,
        REG_ZERO_HIGH   = 3'd3,
        REG_LATCH_TICKS = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [6:0]  pixel_count;
        logic [7:0]  period_top;
        logic [7:0]  one_high;
        logic [7:0]  zero_high;
        logic [16:0] latch_ticks;
    } cfg_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [5:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } item_t;

    typedef struct packed {
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
        logic       data_pin;
        logic       busy_res;
        logic       frame_done;
        logic       rejected;
    } result_t;

    typedef struct packed {
        logic              we;
        logic [PIX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } store_wr_t;

endpackage

FILE: rtl/alsd_cfg.sv
// ----------------------------------------------------------------------------
// alsd_cfg
// apb register file holding the strip timing and size settings
// ----------------------------------------------------------------------------
module alsd_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output alsd_pkg::cfg_t      cfg
);

    alsd_pkg::cfg_t cfg_reg;
    alsd_pkg::cfg_t cfg_next;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                alsd_pkg::REG_PIXEL_COUNT: cfg_next.pixel_count = pwdata[6:0];
                alsd_pkg::REG_PERIOD_TOP:  cfg_next.period_top  = pwdata[7:0];
                alsd_pkg::REG_ONE_HIGH:    cfg_next.one_high    = pwdata[7:0];
                alsd_pkg::REG_ZERO_HIGH:   cfg_next.zero_high   = pwdata[7:0];
                alsd_pkg::REG_LATCH_TICKS: cfg_next.latch_ticks = pwdata[16:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_count <= alsd_pkg::PIXEL_COUNT_RST;
            cfg_reg.period_top  <= alsd_pkg::PERIOD_TOP_RST;
            cfg_reg.one_high    <= alsd_pkg::ONE_HIGH_RST;
            cfg_reg.zero_high   <= alsd_pkg::ZERO_HIGH_RST;
            cfg_reg.latch_ticks <= alsd_pkg::LATCH_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            alsd_pkg::REG_PIXEL_COUNT: prdata = {25'd0, cfg_reg.pixel_count};
            alsd_pkg::REG_PERIOD_TOP:  prdata = {24'd0, cfg_reg.period_top};
            alsd_pkg::REG_ONE_HIGH:    prdata = {24'd0, cfg_reg.one_high};
            alsd_pkg::REG_ZERO_HIGH:   prdata = {24'd0, cfg_reg.zero_high};
            alsd_pkg::REG_LATCH_TICKS: prdata = {15'd0, cfg_reg.latch_ticks};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

FILE: rtl/alsd_store.sv
// ----------------------------------------------------------------------------
// alsd_store
// pixel memory with registered read and per-entry valid bits for zero reset
// ----------------------------------------------------------------------------
module alsd_store (
    input  logic                            clk,
    input  logic                            rst_n,
    input  alsd_pkg::store_wr_t             wr,
    input  logic                            re,
    input  logic [alsd_pkg::PIX_W-1:0]      raddr,
    output logic [alsd_pkg::WORD_W-1:0]     rdata
);

    logic [alsd_pkg::WORD_W-1:0]     mem [alsd_pkg::MAX_PIXELS];
    logic [alsd_pkg::MAX_PIXELS-1:0] valid_reg;
    logic [alsd_pkg::WORD_W-1:0]     rd_data_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    // never written entries read as zero
    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: rtl/alsd_core.sv
// ----------------------------------------------------------------------------
// alsd_core
// phase sequencer: store accesses, bit timing, latch gap and result fields
// ----------------------------------------------------------------------------
module alsd_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  alsd_pkg::cfg_t                  cfg,
    input  logic [2:0]                      in_mode,
    input  logic [5:0]                      in_idx,
    input  logic                            complete,
    input  alsd_pkg::item_t                 item,
    input  logic [alsd_pkg::WORD_W-1:0]     stg_rdata,
    input  logic [alsd_pkg::WORD_W-1:0]     dsp_rdata,
    output logic [alsd_pkg::PIX_W-1:0]      stg_raddr,
    output logic [alsd_pkg::PIX_W-1:0]      dsp_raddr,
    output alsd_pkg::store_wr_t             stg_wr,
    output alsd_pkg::store_wr_t             dsp_wr,
    output alsd_pkg::result_t               res
);

    alsd_pkg::phase_t              phase_reg, phase_next;
    logic [alsd_pkg::PIX_W-1:0]    pixel_pos_reg, pixel_pos_next;
    logic [4:0]                    bit_pos_reg, bit_pos_next;
    logic [7:0]                    tick_reg, tick_next;
    logic [16:0]                   gap_reg, gap_next;
    logic                          pin_reg, pin_next;

    logic [alsd_pkg::CNT_W-1:0]    pc_ext;
    logic [alsd_pkg::CNT_W-1:0]    eff_n;
    logic [alsd_pkg::CNT_W-1:0]    idx_ext;
    logic [alsd_pkg::CNT_W-1:0]    in_idx_ext;
    logic [alsd_pkg::CNT_W-1:0]    pos_ext;
    logic [alsd_pkg::CNT_W-1:0]    pos_inc;
    logic [16:0]                   eff_latch;
    logic [17:0]                   gap_inc;
    logic                          in_range;
    logic [4:0]                    bit_sel;
    logic [7:0]                    high_ticks;

    assign pc_ext     = alsd_pkg::CNT_W'(cfg.pixel_count);
    assign eff_n      = (pc_ext == '0) ? alsd_pkg::CNT_W'(1) :
                        (pc_ext > alsd_pkg::CNT_W'(alsd_pkg::MAX_PIXELS)) ?
                        alsd_pkg::CNT_W'(alsd_pkg::MAX_PIXELS) : pc_ext;
    assign eff_latch  = (cfg.latch_ticks == 17'd0) ? 17'd1 : cfg.latch_ticks;
    assign idx_ext    = alsd_pkg::CNT_W'(item.pixel_index);
    assign in_idx_ext = alsd_pkg::CNT_W'(in_idx);
    assign pos_ext    = alsd_pkg::CNT_W'(pixel_pos_reg);
    assign pos_inc    = pos_ext + alsd_pkg::CNT_W'(1);
    assign gap_inc    = {1'b0, gap_reg} + 18'd1;
    assign in_range   = idx_ext < eff_n;
    assign bit_sel    = 5'(alsd_pkg::BIT_LAST) - bit_pos_reg;
    assign high_ticks = dsp_rdata[bit_sel] ? cfg.one_high : cfg.zero_high;

    // read addresses follow the incoming item, state is settled at that point
    assign stg_raddr = (in_mode == alsd_pkg::MODE_TICK) ? pixel_pos_reg :
                       in_idx_ext[alsd_pkg::PIX_W-1:0];
    assign dsp_raddr = pixel_pos_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        pixel_pos_next = pixel_pos_reg;
        bit_pos_next   = bit_pos_reg;
        tick_next      = tick_reg;
        gap_next       = gap_reg;
        pin_next       = pin_reg;
        res            = '0;
        stg_wr.we      = 1'b0;
        stg_wr.addr    = idx_ext[alsd_pkg::PIX_W-1:0];
        stg_wr.data    = {item.green, item.red, item.blue};
        dsp_wr.we      = 1'b0;
        dsp_wr.addr    = pixel_pos_reg;
        dsp_wr.data    = stg_rdata;

        unique case (item.mode)
            alsd_pkg::MODE_WRITE:
            begin
                stg_wr.we    = complete && in_range;
                res.rejected = !in_range;
            end
            alsd_pkg::MODE_READ:
            begin
                if (in_range)
                begin
                    res.read_green = stg_rdata[23:16];
                    res.read_red   = stg_rdata[15:8];
                    res.read_blue  = stg_rdata[7:0];
                end
                res.rejected = !in_range;
            end
            alsd_pkg::MODE_COMMIT:
            begin
                if (phase_reg != alsd_pkg::PH_IDLE)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    phase_next     = alsd_pkg::PH_COMMIT;
                    pixel_pos_next = '0;
                end
            end
            alsd_pkg::MODE_DRAW:
            begin
                if (phase_reg != alsd_pkg::PH_IDLE)
                begin
                    res.rejected = 1'b1;
                end
                else
                begin
                    phase_next     = alsd_pkg::PH_SEND;
                    pixel_pos_next = '0;
                    bit_pos_next   = '0;
                    tick_next      = '0;
                end
            end
            alsd_pkg::MODE_TICK:
            begin
                pin_next = 1'b0;
                unique case (phase_reg)
                    alsd_pkg::PH_COMMIT:
                    begin
                        dsp_wr.we = complete && (pos_ext < eff_n);
                        if (pos_inc >= eff_n)
                        begin
                            phase_next     = alsd_pkg::PH_IDLE;
                            pixel_pos_next = '0;
                        end
                        else
                        begin
                            pixel_pos_next = pos_inc[alsd_pkg::PIX_W-1:0];
                        end
                    end
                    alsd_pkg::PH_SEND:
                    begin
                        pin_next = tick_reg < high_ticks;
                        if (tick_reg >= cfg.period_top)
                        begin
                            tick_next = '0;
                            if (bit_pos_reg >= 5'(alsd_pkg::BIT_LAST))
                            begin
                                bit_pos_next = '0;
                                if (pos_inc >= eff_n)
                                begin
                                    phase_next     = alsd_pkg::PH_LATCH;
                                    pixel_pos_next = '0;
                                    gap_next       = '0;
                                end
                                else
                                begin
                                    pixel_pos_next = pos_inc[alsd_pkg::PIX_W-1:0];
                                end
                            end
                            else
                            begin
                                bit_pos_next = bit_pos_reg + 5'd1;
                            end
                        end
                        else
                        begin
                            tick_next = tick_reg + 8'd1;
                        end
                    end
                    alsd_pkg::PH_LATCH:
                    begin
                        if (gap_inc >= {1'b0, eff_latch})
                        begin
                            gap_next       = '0;
                            phase_next     = alsd_pkg::PH_IDLE;
                            res.frame_done = 1'b1;
                        end
                        else
                        begin
                            gap_next = gap_inc[16:0];
                        end
                    end
                    default:
                    begin
                        pin_next = 1'b0;
                    end
                endcase
            end
            default:
            begin
                res.rejected = 1'b1;
            end
        endcase

        res.data_pin = pin_next;
        res.busy_res = phase_next != alsd_pkg::PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= alsd_pkg::PH_IDLE;
            pixel_pos_reg <= '0;
            bit_pos_reg   <= '0;
            tick_reg      <= '0;
            gap_reg       <= '0;
            pin_reg       <= 1'b0;
        end
        else if (complete)
        begin
            phase_reg     <= phase_next;
            pixel_pos_reg <= pixel_pos_next;
            bit_pos_reg   <= bit_pos_next;
            tick_reg      <= tick_next;
            gap_reg       <= gap_next;
            pin_reg       <= pin_next;
        end
    end

    // latch gap starts with the bit counters cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == alsd_pkg::PH_LATCH) |-> (bit_pos_reg == '0 && tick_reg == '0))
        else $error("bit counters not cleared in latch gap");

    // frame end returns the sequencer to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (complete && res.frame_done) |=> (phase_reg == alsd_pkg::PH_IDLE))
        else $error("frame end did not return to idle");

    // bit position never leaves the pixel word
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_pos_reg <= 5'(alsd_pkg::BIT_LAST))
        else $error("bit position out of range");

    // display store is written only by a commit tick
    assert property (@(posedge clk) disable iff (!rst_n)
        dsp_wr.we |-> (phase_reg == alsd_pkg::PH_COMMIT && complete))
        else $error("display write outside commit");

endmodule

FILE: rtl/addressable_led_strip_driver.sv
// ----------------------------------------------------------------------------
// addressable_led_strip_driver
// single-wire rgb led strip driver with staging and display pixel stores
// flow: the store read is issued as a transaction is accepted; state, stores
//   and the result register are updated once the output register is free, and
//   with one item in flight a new item is taken only after the last completes
// reset: asynchronous, clears control state and store valid bits, so both
//   stores read as zero at once; no clearing pass is needed
// ----------------------------------------------------------------------------
module addressable_led_strip_driver (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // pixel_index[5:0], red[13:6], green[21:14],
                                       // blue[29:22], zero fill
    input  logic [2:0]  s_axis_tuser,  // mode[2:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // read_red[7:0], read_green[15:8],
                                       // read_blue[23:16], data_pin[24], busy_res[25],
                                       // frame_done[26], rejected[27], zero fill
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    alsd_pkg::cfg_t              cfg;
    alsd_pkg::item_t             item_reg;
    alsd_pkg::result_t           res;
    alsd_pkg::result_t           out_reg;
    alsd_pkg::store_wr_t         stg_wr;
    alsd_pkg::store_wr_t         dsp_wr;
    logic [alsd_pkg::PIX_W-1:0]  stg_raddr;
    logic [alsd_pkg::PIX_W-1:0]  dsp_raddr;
    logic [alsd_pkg::WORD_W-1:0] stg_rdata;
    logic [alsd_pkg::WORD_W-1:0] dsp_rdata;
    logic                        pend_reg, pend_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        accept;
    logic                        complete;

    // one item in flight: the store read is issued at the accepting edge,
    // the item finishes once the output register is free
    assign s_axis_tready = !pend_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign complete      = pend_reg && (!out_valid_reg || m_axis_tready);

    assign pend_next      = accept ? 1'b1 : (complete ? 1'b0 : pend_reg);
    assign out_valid_next = complete ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.mode        <= s_axis_tuser;
            item_reg.pixel_index <= s_axis_tdata[5:0];
            item_reg.red         <= s_axis_tdata[13:6];
            item_reg.green       <= s_axis_tdata[21:14];
            item_reg.blue        <= s_axis_tdata[29:22];
        end
        if (complete)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg.rejected, out_reg.frame_done, out_reg.busy_res,
                            out_reg.data_pin, out_reg.read_blue, out_reg.read_green,
                            out_reg.read_red};

    alsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // staging store: software writes and reads, commit source
    alsd_store u_stg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (stg_wr),
        .re    (accept),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    // display store: commit target, serializer source
    alsd_store u_dsp (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (dsp_wr),
        .re    (accept),
        .raddr (dsp_raddr),
        .rdata (dsp_rdata)
    );

    alsd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_mode   (s_axis_tuser),
        .in_idx    (s_axis_tdata[5:0]),
        .complete  (complete),
        .item      (item_reg),
        .stg_rdata (stg_rdata),
        .dsp_rdata (dsp_rdata),
        .stg_raddr (stg_raddr),
        .dsp_raddr (dsp_raddr),
        .stg_wr    (stg_wr),
        .dsp_wr    (dsp_wr),
        .res       (res)
    );

endmodule

FILE: test/addressable_led_strip_driver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// addressable_led_strip_driver_test
// self-checking bench: pixel store access, commit copy, frame serialization
// and latch gap are predicted per transaction and checked against the result
// stream, under random source gaps, sink stalls and register settings
// ----------------------------------------------------------------------------
module addressable_led_strip_driver_test;

    // modes above tick have no meaning and must be refused
    localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

    localparam int RANDOM_ITEMS   = 600;
    localparam int PHASE_ITEMS    = 250;
    localparam int IDLE_PCT       = 17;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_AFTER     = 700;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    addressable_led_strip_driver dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // strip model: register copy, both pixel stores and the tick engine
    // ------------------------------------------------------------------
    alsd_pkg::cfg_t    strip_cfg;
    logic [23:0]       staging_mem [alsd_pkg::MAX_PIXELS];
    logic [23:0]       shown_mem [alsd_pkg::MAX_PIXELS];
    alsd_pkg::phase_t  eng_phase;
    logic [6:0]        eng_pix;     // one bit wider than the index so 64 fits
    logic [4:0]        eng_bit;
    logic [7:0]        eng_tick;
    logic [16:0]       eng_gap;
    logic              eng_pin;

    // bench bookkeeping
    alsd_pkg::item_t   pending_items [$];
    alsd_pkg::result_t expected_results [$];
    alsd_pkg::item_t   offer_item;
    logic              in_taken = 1'b0;
    logic              steady = 1'b0;
    logic              pressure_done = 1'b0;
    int unsigned       hold_left = 0;
    int unsigned       accepted_in = 0;
    int unsigned       items_queued = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       mismatch_count = 0;

    initial
    begin
        strip_cfg.pixel_count = alsd_pkg::PIXEL_COUNT_RST;
        strip_cfg.period_top  = alsd_pkg::PERIOD_TOP_RST;
        strip_cfg.one_high    = alsd_pkg::ONE_HIGH_RST;
        strip_cfg.zero_high   = alsd_pkg::ZERO_HIGH_RST;
        strip_cfg.latch_ticks = alsd_pkg::LATCH_TICKS_RST;
        foreach (staging_mem[i])
        begin
            staging_mem[i] = '0;
            shown_mem[i]   = '0;
        end
        eng_phase = alsd_pkg::PH_IDLE;
        eng_pix   = '0;
        eng_bit   = '0;
        eng_tick  = '0;
        eng_gap   = '0;
        eng_pin   = 1'b0;
    end

    // pixel count clamped to 1..MAX_PIXELS
    function automatic logic [6:0] live_count();
        if (strip_cfg.pixel_count == 0)
            return 7'd1;
        if (strip_cfg.pixel_count > alsd_pkg::MAX_PIXELS)
            return 7'(alsd_pkg::MAX_PIXELS);
        return strip_cfg.pixel_count;
    endfunction

    // a zero latch length still costs one tick
    function automatic int unsigned live_latch();
        return (strip_cfg.latch_ticks == 0) ? 1 : strip_cfg.latch_ticks;
    endfunction

    // ticks from draw to frame_done under the current settings
    function automatic int unsigned frame_ticks();
        return 24 * live_count() * (strip_cfg.period_top + 1) + live_latch();
    endfunction

    // one timer tick of the engine, returns one when the latch gap ends
    function automatic logic engine_tick();
        logic [6:0]  n;
        logic [23:0] word;
        logic [7:0]  high;
        n = live_count();
        case (eng_phase)
            alsd_pkg::PH_COMMIT:
            begin
                if (eng_pix < n)
                    shown_mem[eng_pix[5:0]] = staging_mem[eng_pix[5:0]];
                eng_pix = eng_pix + 7'd1;
                if (eng_pix >= n)
                begin
                    eng_phase = alsd_pkg::PH_IDLE;
                    eng_pix   = '0;
                end
                eng_pin = 1'b0;
            end
            alsd_pkg::PH_SEND:
            begin
                word    = (eng_pix < alsd_pkg::MAX_PIXELS) ? shown_mem[eng_pix[5:0]] : '0;
                high    = word[5'(alsd_pkg::BIT_LAST) - eng_bit] ? strip_cfg.one_high
                                                                 : strip_cfg.zero_high;
                eng_pin = (eng_tick < high);
                if (eng_tick >= strip_cfg.period_top)
                begin
                    eng_tick = '0;
                    if (eng_bit >= 5'(alsd_pkg::BIT_LAST))
                    begin
                        eng_bit = '0;
                        eng_pix = eng_pix + 7'd1;
                        if (eng_pix >= n)
                        begin
                            eng_phase = alsd_pkg::PH_LATCH;
                            eng_pix   = '0;
                            eng_gap   = '0;
                        end
                    end
                    else
                        eng_bit = eng_bit + 5'd1;
                end
                else
                    eng_tick = eng_tick + 8'd1;
            end
            alsd_pkg::PH_LATCH:
            begin
                eng_pin = 1'b0;
                eng_gap = eng_gap + 17'd1;
                if (eng_gap >= live_latch())
                begin
                    eng_gap   = '0;
                    eng_phase = alsd_pkg::PH_IDLE;
                    return 1'b1;
                end
            end
            default:
                eng_pin = 1'b0;
        endcase
        return 1'b0;
    endfunction

    // expected result of one accepted transaction
    function automatic alsd_pkg::result_t strip_step(alsd_pkg::item_t it);
        alsd_pkg::result_t res;
        logic              in_range;
        logic [23:0]       word;
        res      = '0;
        in_range = (it.pixel_index < live_count());
        case (it.mode)
            alsd_pkg::MODE_WRITE:
                if (in_range)
                    staging_mem[it.pixel_index] = {it.green, it.red, it.blue};
                else
                    res.rejected = 1'b1;
            alsd_pkg::MODE_READ:
                if (in_range)
                begin
                    word           = staging_mem[it.pixel_index];
                    res.read_green = word[23:16];
                    res.read_red   = word[15:8];
                    res.read_blue  = word[7:0];
                end
                else
                    res.rejected = 1'b1;
            alsd_pkg::MODE_COMMIT:
                if (eng_phase != alsd_pkg::PH_IDLE)
                    res.rejected = 1'b1;
                else
                begin
                    eng_phase = alsd_pkg::PH_COMMIT;
                    eng_pix   = '0;
                end
            alsd_pkg::MODE_DRAW:
                if (eng_phase != alsd_pkg::PH_IDLE)
                    res.rejected = 1'b1;
                else
                begin
                    eng_phase = alsd_pkg::PH_SEND;
                    eng_pix   = '0;
                    eng_bit   = '0;
                    eng_tick  = '0;
                end
            alsd_pkg::MODE_TICK:
                res.frame_done = engine_tick();
            default:
                res.rejected = 1'b1;
        endcase
        res.data_pin = eng_pin;
        res.busy_res = (eng_phase != alsd_pkg::PH_IDLE);
        return res;
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // input side: accepted transactions go through the model, results are
    // checked in order against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        alsd_pkg::result_t want;
        alsd_pkg::result_t got;
        logic              moved;
        moved = 1'b0;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_results.push_back(strip_step(offer_item));
            in_taken = 1'b1;
            accepted_in++;
            moved = 1'b1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            moved           = 1'b1;
            got.read_red    = m_axis_tdata[7:0];
            got.read_green  = m_axis_tdata[15:8];
            got.read_blue   = m_axis_tdata[23:16];
            got.data_pin    = m_axis_tdata[24];
            got.busy_res    = m_axis_tdata[25];
            got.frame_done  = m_axis_tdata[26];
            got.rejected    = m_axis_tdata[27];
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no expectation pending: %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("read_red", want.read_red, got.read_red);
                check_field("read_green", want.read_green, got.read_green);
                check_field("read_blue", want.read_blue, got.read_blue);
                check_field("data_pin", 8'(want.data_pin), 8'(got.data_pin));
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
                check_field("rejected", 8'(want.rejected), 8'(got.rejected));
            end
        end
        // watchdog: a long stretch with no transaction on either stream
        if (moved)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // source: next item at the falling edge once the previous one is taken
    always @(negedge clk)
    begin : driver
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
            begin
                offer_item    = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {2'b00, offer_item.blue, offer_item.green,
                                  offer_item.red, offer_item.pixel_index};
                s_axis_tuser  <= offer_item.mode;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // sink: random stalls, plus one long hold-off so the block backs up
    always @(negedge clk)
    begin : sink_pace
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (!pressure_done && accepted_in >= HOLD_AFTER && pending_items.size() > 20)
        begin
            pressure_done = 1'b1;
            hold_left     = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic alsd_pkg::item_t make_item(logic [2:0] mode, logic [5:0] idx,
                                                  logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b);
        alsd_pkg::item_t it;
        it.mode        = mode;
        it.pixel_index = idx;
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        return it;
    endfunction

    function automatic alsd_pkg::item_t rand_item(logic [2:0] mode);
        return make_item(mode, 6'($urandom_range(63)), 8'($urandom), 8'($urandom),
                         8'($urandom));
    endfunction

    // mostly inside the strip, now and then anywhere
    function automatic logic [5:0] pick_index();
        if ($urandom_range(7) == 0)
            return 6'($urandom_range(63));
        return 6'($urandom_range(live_count() - 1));
    endfunction

    // store traffic, commits, draws and the odd refused request
    function automatic alsd_pkg::item_t noise_item();
        int unsigned     pick;
        alsd_pkg::item_t it;
        pick = $urandom_range(99);
        it   = rand_item(alsd_pkg::MODE_WRITE);
        if (pick >= 95)
            it.mode = 3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        else if (pick >= 80)
            it.mode = alsd_pkg::MODE_DRAW;
        else if (pick >= 65)
            it.mode = alsd_pkg::MODE_COMMIT;
        else if (pick >= 35)
            it.mode = alsd_pkg::MODE_READ;
        return it;
    endfunction

    task automatic queue_item(alsd_pkg::item_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic add_ticks(int unsigned n, int unsigned noise_pct);
        repeat (n)
        begin
            if ($urandom_range(99) < noise_pct)
                queue_item(noise_item());
            queue_item(rand_item(alsd_pkg::MODE_TICK));
        end
    endtask

    // well-formed frame: fill, check, commit, draw, run out the latch gap
    task automatic add_frame();
        alsd_pkg::item_t it;
        repeat ($urandom_range(1, 4))
        begin
            it             = rand_item(alsd_pkg::MODE_WRITE);
            it.pixel_index = pick_index();
            queue_item(it);
        end
        repeat ($urandom_range(1, 2))
        begin
            it             = rand_item(alsd_pkg::MODE_READ);
            it.pixel_index = pick_index();
            queue_item(it);
        end
        queue_item(rand_item(alsd_pkg::MODE_COMMIT));
        add_ticks(live_count() + $urandom_range(2), 6);
        queue_item(rand_item(alsd_pkg::MODE_DRAW));
        add_ticks(frame_ticks() + $urandom_range(3), 6);
    endtask

    // wait until every queued transaction has come back, then let the
    // pipeline empty out before touching a register
    task automatic settle();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write one register, then read it back
    task automatic write_reg(alsd_pkg::reg_idx_t r, logic [31:0] value);
        logic [31:0] readback;
        logic [31:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            alsd_pkg::REG_PIXEL_COUNT: strip_cfg.pixel_count = value[6:0];
            alsd_pkg::REG_PERIOD_TOP:  strip_cfg.period_top  = value[7:0];
            alsd_pkg::REG_ONE_HIGH:    strip_cfg.one_high    = value[7:0];
            alsd_pkg::REG_ZERO_HIGH:   strip_cfg.zero_high   = value[7:0];
            default:                   strip_cfg.latch_ticks = value[16:0];
        endcase
        case (r)
            alsd_pkg::REG_PIXEL_COUNT: want = 32'(strip_cfg.pixel_count);
            alsd_pkg::REG_PERIOD_TOP:  want = 32'(strip_cfg.period_top);
            alsd_pkg::REG_ONE_HIGH:    want = 32'(strip_cfg.one_high);
            alsd_pkg::REG_ZERO_HIGH:   want = 32'(strip_cfg.zero_high);
            default:                   want = 32'(strip_cfg.latch_ticks);
        endcase
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== want)
        begin
            $error("prdata mismatch: expected %0h, actual %0h", want, readback);
            mismatch_count++;
        end
    endtask

    task automatic configure(logic [6:0] count, logic [7:0] period, logic [7:0] one_t,
                             logic [7:0] zero_t, logic [16:0] latch);
        settle();
        write_reg(alsd_pkg::REG_PIXEL_COUNT, 32'(count));
        write_reg(alsd_pkg::REG_PERIOD_TOP, 32'(period));
        write_reg(alsd_pkg::REG_ONE_HIGH, 32'(one_t));
        write_reg(alsd_pkg::REG_ZERO_HIGH, 32'(zero_t));
        write_reg(alsd_pkg::REG_LATCH_TICKS, 32'(latch));
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned random_start;
        int unsigned phase_end;
        int unsigned p;
        logic [6:0]  cnt;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // three pixels, one bits high the whole period,
        // zero latch length
        configure(7'd3, 8'd2, 8'd255, 8'd1, 17'd0);
        queue_item(make_item(alsd_pkg::MODE_WRITE, 6'd0, 8'hff, 8'h00, 8'ha5));
        queue_item(make_item(alsd_pkg::MODE_WRITE, 6'd2, 8'h00, 8'hff, 8'h5a));
        // first index past the strip
        queue_item(make_item(alsd_pkg::MODE_WRITE, 6'd3, 8'h11, 8'h22, 8'h33));
        queue_item(make_item(alsd_pkg::MODE_WRITE, 6'd63, 8'hff, 8'hff, 8'hff));
        queue_item(make_item(alsd_pkg::MODE_READ, 6'd0, 8'h00, 8'h00, 8'h00));
        queue_item(make_item(alsd_pkg::MODE_READ, 6'd2, 8'hff, 8'hff, 8'hff));
        // never written
        queue_item(make_item(alsd_pkg::MODE_READ, 6'd1, 8'h00, 8'h00, 8'h00));
        queue_item(make_item(alsd_pkg::MODE_READ, 6'd63, 8'h00, 8'h00, 8'h00));
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++)
            queue_item(make_item(3'(m), 6'd63, 8'hff, 8'hff, 8'hff));
        // tick with engine idle
        queue_item(make_item(alsd_pkg::MODE_TICK, 6'd0, 8'h00, 8'h00, 8'h00));
        queue_item(make_item(alsd_pkg::MODE_COMMIT, 6'd0, 8'h00, 8'h00, 8'h00));
        // busy, refused
        queue_item(make_item(alsd_pkg::MODE_COMMIT, 6'd0, 8'h00, 8'h00, 8'h00));
        queue_item(make_item(alsd_pkg::MODE_DRAW, 6'd0, 8'h00, 8'h00, 8'h00));
        // store access while busy
        queue_item(make_item(alsd_pkg::MODE_WRITE, 6'd1, 8'h12, 8'h34, 8'h56));
        queue_item(make_item(alsd_pkg::MODE_READ, 6'd1, 8'h00, 8'h00, 8'h00));
        add_ticks(3, 0);
        queue_item(make_item(alsd_pkg::MODE_DRAW, 6'd0, 8'h00, 8'h00, 8'h00));
        queue_item(make_item(alsd_pkg::MODE_READ, 6'd0, 8'h00, 8'h00, 8'h00));
        add_ticks(frame_ticks() + 2, 0);

        // pixel count above the store size clamps to the whole store
        configure(7'd100, 8'd2, 8'd2, 8'd1, 17'd3);
        queue_item(make_item(alsd_pkg::MODE_WRITE, 6'd63, 8'h81, 8'h7e, 8'hc3));
        queue_item(make_item(alsd_pkg::MODE_READ, 6'd63, 8'h00, 8'h00, 8'h00));
        queue_item(make_item(alsd_pkg::MODE_COMMIT, 6'd0, 8'h00, 8'h00, 8'h00));
        add_ticks(alsd_pkg::MAX_PIXELS + 1, 4);

        // longest bit and latch, then both cut short while running
        configure(7'd1, 8'd255, 8'd255, 8'd1, 17'd131071);
        queue_item(make_item(alsd_pkg::MODE_WRITE, 6'd0, 8'h00, 8'h80, 8'h01));
        queue_item(make_item(alsd_pkg::MODE_COMMIT, 6'd0, 8'h00, 8'h00, 8'h00));
        add_ticks(2, 0);
        queue_item(make_item(alsd_pkg::MODE_DRAW, 6'd0, 8'h00, 8'h00, 8'h00));
        add_ticks(512, 0);
        settle();
        write_reg(alsd_pkg::REG_PERIOD_TOP, 32'd2);
        add_ticks(80, 0);
        settle();
        write_reg(alsd_pkg::REG_LATCH_TICKS, 32'd5);
        add_ticks(3, 0);

        // full strip draw, zero bits high the whole period, strip shrunk
        // while the second pixel is on the wire
        configure(7'd64, 8'd2, 8'd1, 8'd255, 17'd2);
        queue_item(make_item(alsd_pkg::MODE_DRAW, 6'd0, 8'h00, 8'h00, 8'h00));
        add_ticks(100, 0);
        settle();
        write_reg(alsd_pkg::REG_PIXEL_COUNT, 32'd1);
        add_ticks(60, 0);

        // random phases, each with fresh settings; one runs without gaps
        random_start = items_queued;
        p = 0;
        while (items_queued - random_start < RANDOM_ITEMS)
        begin
            case ($urandom_range(9))
                0:          cnt = 7'd0;
                1, 2, 3, 4: cnt = 7'd1;
                5, 6, 7:    cnt = 7'd2;
                8:          cnt = 7'd3;
                default:    cnt = 7'd4;
            endcase
            configure(cnt, 8'($urandom_range(2, 4)), 8'($urandom_range(1, 6)),
                      8'($urandom_range(1, 6)), 17'($urandom_range(0, 12)));
            steady    = (p == 0);
            phase_end = items_queued + PHASE_ITEMS;
            while (items_queued < phase_end)
            begin
                if ($urandom_range(9) == 0)
                    queue_item(noise_item());
                else
                    add_frame();
            end
            p++;
        end

        settle();
        steady = 1'b0;
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
